@@ hdl/pac_pkg.sv @@
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants for the pointer acceleration curve block.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int CURVE_POINTS = 8;
  localparam int AXIS_COUNT   = 2;
  localparam int IDX_W = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
  localparam int CNT_W = $clog2(CURVE_POINTS + 1);

  localparam int UNITY       = 1000;
  localparam int DT_MAX_MS   = 100;
  localparam int SPEED_LIMIT = 1000000;
  localparam int FACTOR_LOW  = 100;
  localparam int FACTOR_HIGH = 20000;

  localparam int QUEUE_DEPTH = 2;

  // shared divider: numerator covers a 15x20 bit product, divisor a speed step
  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 20;

  // floor(n / 125) == (n * RECIP_125) >> 34 for every n below 2**27
  localparam logic [27:0] RECIP_125 = 28'd137438954;

  typedef enum logic [1:0] {
    K_MOTION,
    K_ZERO,
    K_POINT
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic         axis;
    logic         neg;
    logic [15:0]  mag;
    logic [31:0]  time_ms;
    logic [2:0]   point_index;
    logic [19:0]  point_speed;
    logic [14:0]  point_factor;
  } q_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DT,
    B_SPD,
    B_WALK,
    B_IMUL,
    B_IDIV,
    B_FLIP,
    B_SDIV
  } bstate_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hdl/pac_if.sv @@
// ----------------------------------------------------------------------------
// pac_if
// Request and result channels of the pointer acceleration curve block.
// ----------------------------------------------------------------------------
interface pac_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        axis;
  logic signed [15:0] motion_delta;
  logic [31:0] time_ms;
  logic [2:0]  point_index;
  logic [19:0] point_speed;
  logic [14:0] point_factor;

  modport source (
    output valid, req_type, axis, motion_delta, time_ms,
           point_index, point_speed, point_factor,
    input  ready
  );
  modport sink (
    input  valid, req_type, axis, motion_delta, time_ms,
           point_index, point_speed, point_factor,
    output ready
  );
endinterface

interface pac_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] scaled_delta;
  logic [14:0] factor_used;

  modport source (output valid, scaled_delta, factor_used, input ready);
  modport sink   (input valid, scaled_delta, factor_used, output ready);
endinterface

@@ hdl/pointer_acceleration_curve.sv @@
// ----------------------------------------------------------------------------
// pointer_acceleration_curve
// Piecewise-linear pointer acceleration with per-axis remainder.
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// in_ch     in   valid/ready   req_type axis motion_delta time_ms point_*
// out_ch    out  valid/ready   scaled_delta factor_used
// cfg       in   cfg_we        cfg_wdata = points_in_use
//
// Point writes and zero-delta requests retire in the back part's idle state.
// A motion request holds the back part through a speed divide, a walk over
// the curve points it visits (skipped with an empty curve) and, when it
// interpolates, a second pass through the shared divider; the scaling by
// 1/1000 is a reciprocal multiply. A two-entry queue lets the front keep
// accepting while the back works; a full result register stalls only the back.
// Synchronous reset clears axis history; curve points are undefined until
// written.
module pointer_acceleration_curve
  import pac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pac_in_if.sink     in_ch,
  pac_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic     push;
  q_item_t  push_item;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_item_t  q_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pac_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  pac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  pac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_ch    (out_ch)
  );

endmodule

@@ hdl/pac_front.sv @@
// ----------------------------------------------------------------------------
// pac_front
// Accepts requests, classifies them and clamps point data for the queue.
// ----------------------------------------------------------------------------
module pac_front
  import pac_pkg::*;
(
  pac_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    push,
  output q_item_t push_item
);

  logic drop;

  assign in_ch.ready = !q_full;

  always_comb begin
    push_item.axis        = in_ch.axis;
    push_item.neg         = in_ch.motion_delta[15];
    push_item.mag         = in_ch.motion_delta[15] ? 16'(-in_ch.motion_delta)
                                                   : 16'(in_ch.motion_delta);
    push_item.time_ms     = in_ch.time_ms;
    push_item.point_index = in_ch.point_index;
    push_item.point_speed = (in_ch.point_speed > 20'(SPEED_LIMIT)) ? 20'(SPEED_LIMIT)
                                                                   : in_ch.point_speed;
    if (in_ch.point_factor < 15'(FACTOR_LOW)) begin
      push_item.point_factor = 15'(FACTOR_LOW);
    end else if (in_ch.point_factor > 15'(FACTOR_HIGH)) begin
      push_item.point_factor = 15'(FACTOR_HIGH);
    end else begin
      push_item.point_factor = in_ch.point_factor;
    end

    drop = 1'b0;
    if (in_ch.req_type) begin
      push_item.kind = K_POINT;
      drop = (32'(in_ch.point_index) >= CURVE_POINTS);
    end else begin
      push_item.kind = (in_ch.motion_delta == '0) ? K_ZERO : K_MOTION;
      drop = (32'(in_ch.axis) >= AXIS_COUNT);
    end
  end

  assign push = in_ch.valid && !q_full && !drop;

endmodule

@@ hdl/pac_queue.sv @@
// ----------------------------------------------------------------------------
// pac_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module pac_queue
  import pac_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  q_item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  count;
  logic               do_pop;

  assign full     = (count == CNT_QW'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/pac_div.sv @@
// ----------------------------------------------------------------------------
// pac_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pac_div
  import pac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] acc;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;
  logic [STEP_W-1:0]    steps;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  assign shifted = {acc, quo[DIV_NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      acc <= fits ? DIV_DEN_W'(shifted - {1'b0, den}) : DIV_DEN_W'(shifted);
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ hdl/pac_back.sv @@
// ----------------------------------------------------------------------------
// pac_back
// Sequencer: curve writes, speed estimate, curve walk, scaling with remainder.
// ----------------------------------------------------------------------------
module pac_back
  import pac_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  q_item_t       q_item,
  output logic          q_pop,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata,
  output div_req_t      div_req,
  input  div_rsp_t      div_rsp,
  pac_out_if.source     out_ch
);

  bstate_t state, state_next;

  logic [19:0] spd_tab [CURVE_POINTS];
  logic [14:0] fac_tab [CURVE_POINTS];

  logic [31:0] last_time [AXIS_COUNT];
  logic        last_neg  [AXIS_COUNT];
  logic        last_pos  [AXIS_COUNT];
  logic signed [10:0] remainder [AXIS_COUNT];

  logic [3:0]  points_in_use;
  q_item_t     cur;
  logic [24:0] speed;
  logic [CNT_W-1:0] k;
  logic [19:0] prev_s;
  logic [14:0] prev_f;
  logic [14:0] factor;
  logic [19:0] i_dspd;
  logic [19:0] i_den;
  logic [14:0] i_fmag;
  logic        i_neg;
  logic        t_neg;
  logic [29:0] t_reg;
  logic [20:0] q_reg;

  logic        out_valid;
  logic signed [15:0] out_delta;
  logic [14:0] out_factor;

  // combinational helpers
  logic [31:0] lt;
  logic [31:0] diff;
  logic [6:0]  dt;
  logic [4:0]  n_eff;
  logic [CNT_W-1:0] last_k;
  logic [19:0] s_k;
  logic [14:0] f_k;
  logic        flip;
  logic [14:0] f_eff;
  logic signed [16:0] raw_s;
  logic signed [32:0] total;
  logic [31:0] t_mag;
  logic [15:0] f_adj;
  logic [54:0] q_prod;
  logic [29:0] r_mag;
  logic signed [15:0] q_sat;
  logic signed [10:0] r_s;
  logic        out_free;
  logic        sdiv_ok;
  logic        sdiv_seen;

  assign out_free = !out_valid || out_ch.ready;

  // result register loads once the quotient is ready and the output is free
  assign sdiv_ok = (state == B_SDIV) && sdiv_seen && out_free;

  always_comb begin
    lt   = last_time[cur.axis];
    diff = cur.time_ms - lt;
    if (lt != '0 && cur.time_ms > lt) begin
      dt = (diff > 32'(DT_MAX_MS)) ? 7'(DT_MAX_MS) : diff[6:0];
    end else begin
      dt = 7'd1;
    end

    n_eff  = (32'(points_in_use) > CURVE_POINTS) ? 5'(CURVE_POINTS) : {1'b0, points_in_use};
    last_k = CNT_W'(n_eff - 5'd1);
    s_k    = spd_tab[k[IDX_W-1:0]];
    f_k    = fac_tab[k[IDX_W-1:0]];

    // direction reversal caps the factor at unity
    flip  = (last_neg[cur.axis] && !cur.neg) || (last_pos[cur.axis] && cur.neg);
    f_eff = (flip && factor > 15'(UNITY)) ? 15'(UNITY) : factor;
    raw_s = cur.neg ? -$signed({1'b0, cur.mag}) : $signed({1'b0, cur.mag});
    total = raw_s * $signed({1'b0, f_eff}) + 33'(remainder[cur.axis]);
    t_mag = total[32] ? 32'(-total) : 32'(total);

    f_adj = i_neg ? 16'({1'b0, prev_f} - div_rsp.quo[15:0])
                  : 16'({1'b0, prev_f} + div_rsp.quo[15:0]);

    // magnitude / 1000 as (magnitude / 8) / 125 by reciprocal multiply
    q_prod = 55'(t_reg[29:3]) * 55'(RECIP_125);
    r_mag  = t_reg - 30'(q_reg) * 30'(UNITY);
    if (t_neg) begin
      q_sat = (q_reg > 21'd32768) ? -16'sd32768 : -$signed(q_reg[15:0]);
      r_s   = -$signed({1'b0, r_mag[9:0]});
    end else begin
      q_sat = (q_reg > 21'd32767) ? 16'sd32767 : $signed(q_reg[15:0]);
      r_s   = $signed({1'b0, r_mag[9:0]});
    end
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    div_req     = '0;
    unique case (state)
      B_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_item.kind == K_MOTION) begin
          state_next = B_DT;
        end
      end
      B_DT: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(cur.mag) * DIV_NUM_W'(UNITY);
        div_req.den   = DIV_DEN_W'(dt);
        state_next    = B_SPD;
      end
      B_SPD: begin
        if (div_rsp.done) begin
          state_next = (points_in_use == '0) ? B_FLIP : B_WALK;
        end
      end
      B_WALK: begin
        if (25'(s_k) >= speed) begin
          state_next = (k == '0 || s_k <= prev_s) ? B_FLIP : B_IMUL;
        end else if (k == last_k) begin
          state_next = B_FLIP;
        end
      end
      B_IMUL: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(i_fmag) * DIV_NUM_W'(i_dspd);
        div_req.den   = i_den;
        state_next    = B_IDIV;
      end
      B_IDIV: begin
        if (div_rsp.done) begin
          state_next = B_FLIP;
        end
      end
      B_FLIP: begin
        state_next = B_SDIV;
      end
      B_SDIV: begin
        if (sdiv_ok) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sdiv_seen <= 1'b0;
    end else if (sdiv_ok) begin
      sdiv_seen <= 1'b0;
    end else if (state == B_SDIV) begin
      sdiv_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid && q_item.kind == K_POINT) begin
      spd_tab[q_item.point_index[IDX_W-1:0]] <= q_item.point_speed;
      fac_tab[q_item.point_index[IDX_W-1:0]] <= q_item.point_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= 4'd1;
      out_valid     <= 1'b0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        last_time[a] <= '0;
        last_neg[a]  <= 1'b0;
        last_pos[a]  <= 1'b0;
        remainder[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        points_in_use <= cfg_wdata;
      end
      if (sdiv_ok) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (state == B_IDLE && q_valid && q_item.kind == K_ZERO) begin
        last_time[q_item.axis] <= q_item.time_ms;
      end
      if (sdiv_ok) begin
        remainder[cur.axis]     <= r_s;
        last_neg[cur.axis]      <= cur.neg;
        last_pos[cur.axis]      <= !cur.neg;
        last_time[cur.axis]     <= cur.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (sdiv_ok) begin
      out_delta  <= q_sat;
      out_factor <= factor;
    end
    unique case (state)
      B_SPD: begin
        speed  <= div_rsp.quo[24:0];
        k      <= '0;
        factor <= 15'(UNITY);
      end
      B_WALK: begin
        if (25'(s_k) >= speed) begin
          factor <= f_k;
          i_dspd <= 20'(speed - 25'(prev_s));
          i_den  <= s_k - prev_s;
          i_neg  <= (f_k < prev_f);
          i_fmag <= (f_k < prev_f) ? prev_f - f_k : f_k - prev_f;
        end else if (k == last_k) begin
          factor <= f_k;
        end else begin
          prev_s <= s_k;
          prev_f <= f_k;
          k      <= k + 1'b1;
        end
      end
      B_IDIV: begin
        if (div_rsp.done) begin
          factor <= f_adj[14:0];
        end
      end
      B_FLIP: begin
        factor <= f_eff;
        t_neg  <= total[32];
        t_reg  <= t_mag[29:0];
      end
      B_SDIV: begin
        q_reg <= q_prod[54:34];
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.scaled_delta = out_delta;
  assign out_ch.factor_used  = out_factor;

endmodule
